// ===== hw/rtl/bdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdm_pkg: shared definitions for the block density mask regularizer
// Block class codes, register indexes and configuration defaults.
// ----------------------------------------------------------------------------
package bdm_pkg;

   localparam int DEF_MAX_BLOCKS_WIDE = 256;
   localparam int DEF_MAX_BLOCKS_HIGH = 256;
   localparam int DEF_BLOCK_SIZE      = 4;

   localparam int MIN_BLOCKS = 3;

   typedef enum logic [1:0] {
      CLS_EMPTY   = 2'd0,
      CLS_PARTIAL = 2'd1,
      CLS_FULL    = 2'd2
   } cls_type;

   typedef enum logic [1:0] {
      REG_BLOCKS_WIDE = 2'd0,
      REG_BLOCKS_HIGH = 2'd1,
      REG_ERODE_MIN   = 2'd2,
      REG_DILATE_MIN  = 2'd3
   } reg_idx_type;

   localparam logic [8:0] RST_BLOCKS_WIDE = 9'd160;
   localparam logic [8:0] RST_BLOCKS_HIGH = 9'd120;
   localparam logic [3:0] RST_ERODE_MIN   = 4'd1;
   localparam logic [3:0] RST_DILATE_MIN  = 4'd3;

   localparam logic [7:0] VAL_FULL  = 8'd255;
   localparam logic [7:0] VAL_EMPTY = 8'd0;

endpackage

// ===== hw/rtl/bdm_ram.sv =====
// ----------------------------------------------------------------------------
// bdm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdm_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/block_density_mask_regularizer.sv =====
// ----------------------------------------------------------------------------
// block_density_mask_regularizer: block mask builder with erode/dilate passes
// Counts set pixels per block, classes blocks, then regularizes the frame.
// ----------------------------------------------------------------------------
// Usage. Items enter on the req_ channel (req_valid, req_stall) and results
// leave on the rsp_ channel (rsp_valid, rsp_stall). A mode 0 item carries one
// mask pixel in raster order and gives no result; in S_IDLE it reads the
// running count of its block column from the count RAM, and in S_PX_WR it
// writes it back (and, on the last pixel of a block, stores the block class).
// After the last pixel of the frame the block runs the erode pass and then the
// dilate pass over the interior blocks through the one read port of the class
// RAM, reading each block's 3x3 neighborhood and then writing the block back;
// req_stall is high throughout. A mode 1 item reads one block's final value
// from the class RAM; the value enters the output register once that register
// is free, and a finished result waits there while the next item is already
// accepted. Reset clears the pixel position, the count valid bits, the
// processed flag and the output valid flag; the class RAM is undefined until
// a frame fills it. The registers are written over the APB-style port; the
// user must write them only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module block_density_mask_regularizer
   import bdm_pkg::*;
#(
   parameter int MAX_BLOCKS_WIDE = DEF_MAX_BLOCKS_WIDE,
   parameter int MAX_BLOCKS_HIGH = DEF_MAX_BLOCKS_HIGH,
   parameter int BLOCK_SIZE      = DEF_BLOCK_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_pixel,
   input  logic [7:0]  req_read_block_row,
   input  logic [7:0]  req_read_block_col,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_block_value,
   output logic        rsp_frame_done,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int WW  = $clog2(MAX_BLOCKS_WIDE + 1);
   localparam int HW  = $clog2(MAX_BLOCKS_HIGH + 1);
   localparam int CIW = $clog2(MAX_BLOCKS_WIDE);
   localparam int AW  = $clog2(MAX_BLOCKS_WIDE * MAX_BLOCKS_HIGH);
   localparam int SBW = $clog2(BLOCK_SIZE);
   localparam int CW  = $clog2(BLOCK_SIZE * BLOCK_SIZE + 1);
   localparam logic [SBW-1:0] SUB_LAST = SBW'(BLOCK_SIZE - 1);
   localparam logic [CW-1:0]  CNT_FULL = CW'(BLOCK_SIZE * BLOCK_SIZE);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PX_WR  = 6'b000010,
      S_RG_RD  = 6'b000100,
      S_RG_WB  = 6'b001000,
      S_RD_OUT = 6'b010000,
      S_UNUSED = 6'b100000
   } state_type;

   // Configuration registers.
   logic [8:0] blocks_wide_ff, blocks_high_ff;
   logic [3:0] erode_min_ff, dilate_min_ff;
   logic       cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_wide_ff <= RST_BLOCKS_WIDE;
         blocks_high_ff <= RST_BLOCKS_HIGH;
         erode_min_ff   <= RST_ERODE_MIN;
         dilate_min_ff  <= RST_DILATE_MIN;
      end else if (cfg_wr) begin
         case (reg_idx_type'(paddr[3:2]))
            REG_BLOCKS_WIDE: blocks_wide_ff <= pwdata[8:0];
            REG_BLOCKS_HIGH: blocks_high_ff <= pwdata[8:0];
            REG_ERODE_MIN:   erode_min_ff   <= pwdata[3:0];
            REG_DILATE_MIN:  dilate_min_ff  <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx_type'(paddr[3:2]))
         REG_BLOCKS_WIDE: prdata = {23'd0, blocks_wide_ff};
         REG_BLOCKS_HIGH: prdata = {23'd0, blocks_high_ff};
         REG_ERODE_MIN:   prdata = {28'd0, erode_min_ff};
         REG_DILATE_MIN:  prdata = {28'd0, dilate_min_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // Frame geometry, clamped to the supported range.
   logic [WW-1:0] w;
   logic [HW-1:0] h;

   always_comb begin
      if (int'(blocks_wide_ff) < MIN_BLOCKS) begin
         w = WW'(MIN_BLOCKS);
      end else if (int'(blocks_wide_ff) > MAX_BLOCKS_WIDE) begin
         w = WW'(MAX_BLOCKS_WIDE);
      end else begin
         w = WW'(blocks_wide_ff);
      end
      if (int'(blocks_high_ff) < MIN_BLOCKS) begin
         h = HW'(MIN_BLOCKS);
      end else if (int'(blocks_high_ff) > MAX_BLOCKS_HIGH) begin
         h = HW'(MAX_BLOCKS_HIGH);
      end else begin
         h = HW'(blocks_high_ff);
      end
   end

   function automatic logic [AW-1:0] cell_addr(input logic [HW-1:0] r,
                                               input logic [WW-1:0] c);
      cell_addr = AW'(r) * AW'(MAX_BLOCKS_WIDE) + AW'(c);
   endfunction

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [WW-1:0]    bc_ff, bc_in;
   logic [SBW-1:0]   sc_ff, sc_in;
   logic [HW-1:0]    br_ff, br_in;
   logic [SBW-1:0]   sr_ff, sr_in;
   logic             processed_ff, processed_in;
   logic             set_ff, set_in;
   logic [MAX_BLOCKS_WIDE-1:0] cnt_vld_ff, cnt_vld_in;

   logic [HW-1:0]    pr_ff, pr_in;
   logic [WW-1:0]    pc_ff, pc_in;
   logic [1:0]       dr_ff, dr_in, dc_ff, dc_in;
   logic             pass_ff, pass_in;
   logic [3:0]       acc_ff, acc_in;
   logic             rd_v_ff, rd_v_in;
   logic             rd_ctr_ff, rd_ctr_in;
   logic [1:0]       center_ff, center_in;

   logic             rd_ok_ff, rd_ok_in;
   logic             rd_done_ff, rd_done_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_value_ff, rsp_value_in;
   logic             rsp_done_ff, rsp_done_in;

   // Memory ports.
   logic             cnt_rd_en, cnt_wr_en;
   logic [CIW-1:0]   cnt_rd_addr;
   logic [CW-1:0]    cnt_wr_data, cnt_q;
   logic             cls_rd_en, cls_wr_en;
   logic [AW-1:0]    cls_rd_addr, cls_wr_addr;
   logic [1:0]       cls_wr_data, cls_q;

   // Scratch values.
   logic             accept, restart, blk_last, border, q_full;
   logic [CW-1:0]    cnt_old, cnt_new;
   logic [3:0]       nb_total;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign q_full    = (cls_q == CLS_FULL);

   always_comb begin
      state_in     = state_ff;
      bc_in        = bc_ff;
      sc_in        = sc_ff;
      br_in        = br_ff;
      sr_in        = sr_ff;
      processed_in = processed_ff;
      set_in       = set_ff;
      cnt_vld_in   = cnt_vld_ff;
      pr_in        = pr_ff;
      pc_in        = pc_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      pass_in      = pass_ff;
      acc_in       = acc_ff;
      rd_v_in      = 1'b0;
      rd_ctr_in    = 1'b0;
      center_in    = center_ff;
      rd_ok_in     = rd_ok_ff;
      rd_done_in   = rd_done_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_done_in  = rsp_done_ff;

      cnt_rd_en    = 1'b0;
      cnt_rd_addr  = bc_ff[CIW-1:0];
      cnt_wr_en    = 1'b0;
      cnt_wr_data  = '0;
      cls_rd_en    = 1'b0;
      cls_rd_addr  = cell_addr(HW'(pr_ff + HW'(dr_ff) - HW'(1)),
                               WW'(pc_ff + WW'(dc_ff) - WW'(1)));
      cls_wr_en    = 1'b0;
      cls_wr_addr  = cell_addr(br_ff, bc_ff);
      cls_wr_data  = CLS_EMPTY;

      restart  = (int'(bc_ff) >= int'(w)) || (int'(br_ff) >= int'(h));
      cnt_old  = cnt_vld_ff[bc_ff[CIW-1:0]] ? cnt_q : '0;
      cnt_new  = cnt_old + CW'(set_ff);
      blk_last = (sc_ff == SUB_LAST) && (sr_ff == SUB_LAST);
      border   = (br_ff == '0) || (bc_ff == '0) || (br_ff == h - HW'(1)) ||
                 (bc_ff == w - WW'(1));
      nb_total = acc_ff + 4'(rd_v_ff & q_full);

      case (state_ff)
         S_IDLE: begin
            if (accept && !req_mode) begin
               // A pixel outside the current geometry restarts the frame.
               set_in      = |req_pixel;
               cnt_rd_en   = 1'b1;
               if (restart) begin
                  cnt_rd_addr = '0;
                  bc_in       = '0;
                  sc_in       = '0;
                  br_in       = '0;
                  sr_in       = '0;
                  cnt_vld_in  = '0;
                  processed_in = 1'b0;
               end else if (bc_ff == '0 && sc_ff == '0 && br_ff == '0 &&
                            sr_ff == '0) begin
                  processed_in = 1'b0;
               end
               state_in = S_PX_WR;
            end else if (accept) begin
               cls_rd_en   = 1'b1;
               cls_rd_addr = cell_addr(HW'(req_read_block_row),
                                       WW'(req_read_block_col));
               rd_ok_in    = processed_ff &&
                             (int'(req_read_block_row) < int'(h)) &&
                             (int'(req_read_block_col) < int'(w));
               rd_done_in  = processed_ff;
               state_in    = S_RD_OUT;
            end
         end

         S_PX_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = blk_last ? '0 : cnt_new;
            cnt_vld_in[bc_ff[CIW-1:0]] = 1'b1;
            if (blk_last) begin
               cls_wr_en = 1'b1;
               if (cnt_new == '0 || border) begin
                  cls_wr_data = CLS_EMPTY;
               end else if (cnt_new < CNT_FULL) begin
                  cls_wr_data = CLS_PARTIAL;
               end else begin
                  cls_wr_data = CLS_FULL;
               end
            end
            state_in = S_IDLE;
            if (sc_ff == SUB_LAST) begin
               sc_in = '0;
               if (bc_ff == w - WW'(1)) begin
                  bc_in = '0;
                  if (sr_ff == SUB_LAST) begin
                     sr_in = '0;
                     if (br_ff == h - HW'(1)) begin
                        // Frame complete: start the erode pass.
                        br_in    = '0;
                        pr_in    = HW'(1);
                        pc_in    = WW'(1);
                        dr_in    = '0;
                        dc_in    = '0;
                        pass_in  = 1'b0;
                        acc_in   = '0;
                        state_in = S_RG_RD;
                     end else begin
                        br_in = br_ff + HW'(1);
                     end
                  end else begin
                     sr_in = sr_ff + SBW'(1);
                  end
               end else begin
                  bc_in = bc_ff + WW'(1);
               end
            end else begin
               sc_in = sc_ff + SBW'(1);
            end
         end

         S_RG_RD: begin
            // Read the 3x3 neighborhood, one entry a cycle.
            cls_rd_en = 1'b1;
            rd_v_in   = 1'b1;
            rd_ctr_in = (dr_ff == 2'd1) && (dc_ff == 2'd1);
            acc_in    = nb_total;
            if (rd_ctr_ff) begin
               center_in = cls_q;
            end
            if (dc_ff == 2'd2) begin
               dc_in = '0;
               if (dr_ff == 2'd2) begin
                  dr_in    = '0;
                  state_in = S_RG_WB;
               end else begin
                  dr_in = dr_ff + 2'd1;
               end
            end else begin
               dc_in = dc_ff + 2'd1;
            end
         end

         S_RG_WB: begin
            cls_wr_addr = cell_addr(pr_ff, pc_ff);
            acc_in      = '0;
            if (!pass_ff) begin
               if (center_ff == CLS_FULL && nb_total < erode_min_ff) begin
                  cls_wr_en   = 1'b1;
                  cls_wr_data = CLS_EMPTY;
               end
            end else if (center_ff != CLS_FULL) begin
               cls_wr_en   = 1'b1;
               cls_wr_data = (nb_total > dilate_min_ff) ? CLS_FULL : CLS_EMPTY;
            end
            state_in = S_RG_RD;
            if (pc_ff == w - WW'(2)) begin
               pc_in = WW'(1);
               if (pr_ff == h - HW'(2)) begin
                  pr_in = HW'(1);
                  if (pass_ff) begin
                     processed_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     pass_in = 1'b1;
                  end
               end else begin
                  pr_in = pr_ff + HW'(1);
               end
            end else begin
               pc_in = pc_ff + WW'(1);
            end
         end

         S_RD_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (rd_ok_ff && q_full) ? VAL_FULL : VAL_EMPTY;
               rsp_done_in  = rd_done_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bc_ff        <= '0;
         sc_ff        <= '0;
         br_ff        <= '0;
         sr_ff        <= '0;
         processed_ff <= 1'b0;
         cnt_vld_ff   <= '0;
         rd_v_ff      <= 1'b0;
         rd_ctr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bc_ff        <= bc_in;
         sc_ff        <= sc_in;
         br_ff        <= br_in;
         sr_ff        <= sr_in;
         processed_ff <= processed_in;
         cnt_vld_ff   <= cnt_vld_in;
         rd_v_ff      <= rd_v_in;
         rd_ctr_ff    <= rd_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff       <= set_in;
      pr_ff        <= pr_in;
      pc_ff        <= pc_in;
      dr_ff        <= dr_in;
      dc_ff        <= dc_in;
      pass_ff      <= pass_in;
      acc_ff       <= acc_in;
      center_ff    <= center_in;
      rd_ok_ff     <= rd_ok_in;
      rd_done_ff   <= rd_done_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_value = rsp_value_ff;
   assign rsp_frame_done  = rsp_done_ff;

   // Running set-pixel counts, one per block column of the current block row.
   bdm_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_BLOCKS_WIDE)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (bc_ff[CIW-1:0]),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_q)
   );

   // Block classes of the whole frame.
   bdm_ram #(
      .WIDTH (2),
      .DEPTH (MAX_BLOCKS_WIDE * MAX_BLOCKS_HIGH)
   ) u_cls_ram (
      .clock   (clock),
      .wr_en   (cls_wr_en),
      .wr_addr (cls_wr_addr),
      .wr_data (cls_wr_data),
      .rd_en   (cls_rd_en),
      .rd_addr (cls_rd_addr),
      .rd_data (cls_q)
   );

endmodule
